// File: rtl/ribop_pkg.sv
// ----------------------------------------------------------------------------
// ROM image bank occupancy parser package
// Shared constants, codes and result types for the parser, its core and its
// result queue.
// ----------------------------------------------------------------------------
`default_nettype none

package ribop_pkg;

  localparam int PRG_BANK_BYTES = 16384;
  localparam int CHR_BANK_BYTES = 8192;
  localparam int TRAINER_BYTES  = 512;

  localparam int HEADER_BYTES = 16;
  localparam int POS_W        = 10;
  localparam int BIB_W        = 16;
  localparam int OCC_W        = 15;
  localparam int BANK_W       = 12;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = FIFO_AW + 1;

  localparam logic [7:0] SIG_BYTE0 = 8'h4E;
  localparam logic [7:0] SIG_BYTE1 = 8'h45;
  localparam logic [7:0] SIG_BYTE2 = 8'h53;
  localparam logic [7:0] SIG_BYTE3 = 8'h1A;

  localparam logic [7:0] FMT_MASK    = 8'h0C;
  localparam logic [7:0] FMT_V2      = 8'h08;
  localparam logic [3:0] EXP_SIZE    = 4'hF;
  localparam logic [7:0] FLAG_FOUR   = 8'h08;
  localparam logic [7:0] FLAG_TRAIN  = 8'h04;
  localparam logic [7:0] FLAG_BATT   = 8'h02;
  localparam logic [7:0] FLAG_VERT   = 8'h01;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_TRAINER = 3'd1,
    PH_PRG     = 3'd2,
    PH_CHR     = 3'd3,
    PH_END     = 3'd4,
    PH_ERROR   = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_BANK   = 2'd1,
    KIND_FINAL  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TRAILING  = 3'd1,
    ST_SHORT     = 3'd2,
    ST_BAD_SIG   = 3'd3,
    ST_UNSUP     = 3'd4,
    ST_TRUNCATED = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    MIR_HORIZ = 2'd0,
    MIR_VERT  = 2'd1,
    MIR_FOUR  = 2'd2
  } mirror_e;

  typedef enum logic {
    REG_PRG = 1'b0,
    REG_CHR = 1'b1
  } region_e;

  typedef struct packed {
    logic [1:0]        kind;
    logic [11:0]       mapper_id;
    logic [3:0]        submapper;
    logic              is_nes20;
    logic              has_battery;
    logic              has_trainer;
    logic [1:0]        mirroring;
    logic              region;
    logic [BANK_W-1:0] bank_index;
    logic [OCC_W-1:0]  occupied;
    logic [2:0]        status;
    logic              end_of_run;
  } result_t;

  typedef struct packed {
    logic [1:0]       num;
    result_t [1:0]    res;
  } push_t;

endpackage

`default_nettype wire

// File: rtl/ribop_fifo.sv
// ----------------------------------------------------------------------------
// Result queue
// Small register queue that takes up to two results per cycle and hands out
// one per cycle while pop_i is high.
// ----------------------------------------------------------------------------
`default_nettype none

module ribop_fifo (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  ribop_pkg::push_t          push_i,
  input  wire                       pop_i,
  output ribop_pkg::result_t        head_o,
  output logic [ribop_pkg::FIFO_CW-1:0] count_o
);
  import ribop_pkg::*;

  result_t              mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wptr_q, wptr_d;
  logic [FIFO_AW-1:0]   rptr_q, rptr_d;
  logic [FIFO_CW-1:0]   count_q, count_d;

  always_comb begin
    wptr_d  = wptr_q + FIFO_AW'(push_i.num);
    rptr_d  = rptr_q + FIFO_AW'(pop_i);
    count_d = count_q + FIFO_CW'(push_i.num) - FIFO_CW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wptr_q] <= push_i.res[0];
    end
    if (push_i.num == 2'd2) begin
      mem_q[wptr_q + FIFO_AW'(1)] <= push_i.res[1];
    end
  end

  assign head_o  = mem_q[rptr_q];
  assign count_o = count_q;

endmodule

`default_nettype wire

// File: rtl/ribop_core.sv
// ----------------------------------------------------------------------------
// Parser core
// Holds the image state, decodes the header, counts bank occupancy and forms
// up to two results for each registered byte.
// ----------------------------------------------------------------------------
`default_nettype none

module ribop_core (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               valid_i,
  input  wire  [7:0]        byte_i,
  input  wire               last_i,
  input  wire  [7:0]        empty_value_i,
  output ribop_pkg::push_t  push_o
);
  import ribop_pkg::*;

  phase_e             phase_q, phase_d;
  logic [7:0]         hdr_q [HEADER_BYTES];
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [BIB_W-1:0]   bib_q, bib_d;
  logic [OCC_W-1:0]   occ_q, occ_d;
  logic [BANK_W-1:0]  bank_q, bank_d;
  logic [BANK_W-1:0]  prg_tot_q, prg_tot_d;
  logic [BANK_W-1:0]  chr_tot_q, chr_tot_d;
  logic [2:0]         err_q, err_d;
  logic               trail_q, trail_d;

  logic               sig_ok;
  logic               fmt_v2;
  logic [3:0]         prg_exp, chr_exp;
  logic [BANK_W-1:0]  hdr_prg_tot, hdr_chr_tot;
  logic [11:0]        hdr_mapper;
  logic [1:0]         hdr_mirror;
  logic               is_chr;
  logic [BIB_W-1:0]   bank_last;
  logic [OCC_W-1:0]   occ_inc;
  logic [BANK_W:0]    bank_next;
  result_t            rep;
  logic [1:0]         num;
  result_t [1:0]      res;
  logic [2:0]         fin_status;

  function automatic phase_e first_region(input logic [BANK_W-1:0] prg_tot,
                                          input logic [BANK_W-1:0] chr_tot);
    phase_e ph;
    if (prg_tot != '0) begin
      ph = PH_PRG;
    end else if (chr_tot != '0) begin
      ph = PH_CHR;
    end else begin
      ph = PH_END;
    end
    return ph;
  endfunction

  assign sig_ok = (hdr_q[0] == SIG_BYTE0) && (hdr_q[1] == SIG_BYTE1) &&
                  (hdr_q[2] == SIG_BYTE2) && (hdr_q[3] == SIG_BYTE3);
  assign fmt_v2      = (hdr_q[7] & FMT_MASK) == FMT_V2;
  assign prg_exp     = hdr_q[9][3:0];
  assign chr_exp     = hdr_q[9][7:4];
  assign hdr_prg_tot = {(fmt_v2 ? prg_exp : 4'd0), hdr_q[4]};
  assign hdr_chr_tot = {(fmt_v2 ? chr_exp : 4'd0), hdr_q[5]};
  assign hdr_mapper  = {(fmt_v2 ? hdr_q[8][3:0] : 4'd0), hdr_q[7][7:4], hdr_q[6][7:4]};
  assign hdr_mirror  = ((hdr_q[6] & FLAG_FOUR) != '0) ? MIR_FOUR :
                       ((hdr_q[6] & FLAG_VERT) != '0) ? MIR_VERT : MIR_HORIZ;

  assign is_chr    = phase_q == PH_CHR;
  assign bank_last = is_chr ? BIB_W'(CHR_BANK_BYTES - 1) : BIB_W'(PRG_BANK_BYTES - 1);
  assign occ_inc   = occ_q + OCC_W'(byte_i != empty_value_i);
  assign bank_next = {1'b0, bank_q} + (BANK_W + 1)'(1);

  always_comb begin
    phase_d   = phase_q;
    pos_d     = pos_q;
    bib_d     = bib_q;
    occ_d     = occ_q;
    bank_d    = bank_q;
    prg_tot_d = prg_tot_q;
    chr_tot_d = chr_tot_q;
    err_d     = err_q;
    trail_d   = trail_q;
    rep       = '0;
    num       = 2'd0;
    res       = '0;
    fin_status = ST_OK;

    unique case (phase_q)
      PH_HEADER: begin
        pos_d = pos_q + POS_W'(1);
        if (pos_q == POS_W'(HEADER_BYTES - 1)) begin
          if (!sig_ok) begin
            err_d   = ST_BAD_SIG;
            phase_d = PH_ERROR;
          end else if (fmt_v2 && (prg_exp == EXP_SIZE || chr_exp == EXP_SIZE)) begin
            err_d   = ST_UNSUP;
            phase_d = PH_ERROR;
          end else begin
            prg_tot_d       = hdr_prg_tot;
            chr_tot_d       = hdr_chr_tot;
            rep.kind        = KIND_HEADER;
            rep.mapper_id   = hdr_mapper;
            rep.submapper   = fmt_v2 ? hdr_q[8][7:4] : 4'd0;
            rep.is_nes20    = fmt_v2;
            rep.has_battery = (hdr_q[6] & FLAG_BATT) != '0;
            rep.has_trainer = (hdr_q[6] & FLAG_TRAIN) != '0;
            rep.mirroring   = hdr_mirror;
            res[0]          = rep;
            num             = 2'd1;
            pos_d           = '0;
            if ((hdr_q[6] & FLAG_TRAIN) != '0) begin
              phase_d = PH_TRAINER;
            end else begin
              phase_d = first_region(hdr_prg_tot, hdr_chr_tot);
              bank_d  = '0;
              bib_d   = '0;
              occ_d   = '0;
            end
          end
        end
      end
      PH_TRAINER: begin
        pos_d = pos_q + POS_W'(1);
        if (pos_q == POS_W'(TRAINER_BYTES - 1)) begin
          pos_d   = '0;
          phase_d = first_region(prg_tot_q, chr_tot_q);
          bank_d  = '0;
          bib_d   = '0;
          occ_d   = '0;
        end
      end
      PH_PRG, PH_CHR: begin
        if (bib_q == bank_last) begin
          rep.kind       = KIND_BANK;
          rep.region     = is_chr ? REG_CHR : REG_PRG;
          rep.bank_index = bank_q;
          rep.occupied   = occ_inc;
          res[0]         = rep;
          num            = 2'd1;
          bib_d          = '0;
          occ_d          = '0;
          bank_d         = bank_next[BANK_W-1:0];
          if (!is_chr && bank_next >= {1'b0, prg_tot_q}) begin
            bank_d  = '0;
            phase_d = (chr_tot_q != '0) ? PH_CHR : PH_END;
          end else if (is_chr && bank_next >= {1'b0, chr_tot_q}) begin
            bank_d  = '0;
            phase_d = PH_END;
          end
        end else begin
          bib_d = bib_q + BIB_W'(1);
          occ_d = occ_inc;
        end
      end
      PH_END: begin
        trail_d = 1'b1;
      end
      default: begin
      end
    endcase

    if (last_i) begin
      priority if (phase_d == PH_HEADER) begin
        fin_status = ST_SHORT;
      end else if (err_d != ST_OK) begin
        fin_status = err_d;
      end else if (phase_d == PH_END) begin
        fin_status = trail_d ? ST_TRAILING : ST_OK;
      end else begin
        fin_status = ST_TRUNCATED;
      end
      rep        = '0;
      rep.kind   = KIND_FINAL;
      rep.status = fin_status;
      if (num == 2'd0) begin
        res[0] = rep;
      end else begin
        res[1] = rep;
      end
      num       = num + 2'd1;
      phase_d   = PH_HEADER;
      pos_d     = '0;
      bib_d     = '0;
      occ_d     = '0;
      bank_d    = '0;
      prg_tot_d = '0;
      chr_tot_d = '0;
      err_d     = ST_OK;
      trail_d   = 1'b0;
    end

    if (num == 2'd1) begin
      res[0].end_of_run = 1'b1;
    end else if (num == 2'd2) begin
      res[1].end_of_run = 1'b1;
    end

    if (!valid_i) begin
      num = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HEADER;
      pos_q     <= '0;
      bib_q     <= '0;
      occ_q     <= '0;
      bank_q    <= '0;
      prg_tot_q <= '0;
      chr_tot_q <= '0;
      err_q     <= ST_OK;
      trail_q   <= 1'b0;
    end else if (valid_i) begin
      phase_q   <= phase_d;
      pos_q     <= pos_d;
      bib_q     <= bib_d;
      occ_q     <= occ_d;
      bank_q    <= bank_d;
      prg_tot_q <= prg_tot_d;
      chr_tot_q <= chr_tot_d;
      err_q     <= err_d;
      trail_q   <= trail_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && phase_q == PH_HEADER) begin
      hdr_q[pos_q[3:0]] <= byte_i;
    end
  end

  assign push_o.num = num;
  assign push_o.res = res;

endmodule

`default_nettype wire

// File: rtl/rom_image_bank_occupancy_parser.sv
// A byte is held in the input register, and its results are written to the
// eight-entry result queue before they are offered. Throughput: one byte per
// cycle while in_ready_o is high; results leave one per cycle when taken.
// Reset: all image state and the empty value clear at once; the block is ready
// as soon as reset is released.
// ----------------------------------------------------------------------------
// ROM image bank occupancy parser
// Registers each image byte, parses it in the core and queues the header,
// bank and final status results for the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module rom_image_bank_occupancy_parser (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [7:0]  cfg_empty_value_i,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire  [7:0]  file_byte_i,
  input  wire         last_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic [1:0]  kind_o,
  output logic [11:0] mapper_id_o,
  output logic [3:0]  submapper_o,
  output logic        is_nes20_o,
  output logic        has_battery_o,
  output logic        has_trainer_o,
  output logic [1:0]  mirroring_o,
  output logic        region_o,
  output logic [11:0] bank_index_o,
  output logic [14:0] occupied_o,
  output logic [2:0]  status_o,
  output logic        end_of_run_o
);
  import ribop_pkg::*;

  logic [7:0]          empty_q;
  logic                s1_valid_q;
  logic [7:0]          s1_byte_q;
  logic                s1_last_q;
  push_t               push;
  result_t             head;
  logic [FIFO_CW-1:0]  count;
  logic [FIFO_CW:0]    credit;
  logic                in_fire;
  logic                pop;

  assign cfg_ready_o = 1'b1;
  assign credit      = {1'b0, count} + (s1_valid_q ? (FIFO_CW + 1)'(2) : '0);
  assign in_ready_o  = credit <= (FIFO_CW + 1)'(FIFO_DEPTH - 2);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = count != '0;
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      empty_q    <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        empty_q <= cfg_empty_value_i;
      end
      s1_valid_q <= in_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_byte_q <= file_byte_i;
      s1_last_q <= last_i;
    end
  end

  ribop_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (s1_valid_q),
    .byte_i        (s1_byte_q),
    .last_i        (s1_last_q),
    .empty_value_i (empty_q),
    .push_o        (push)
  );

  ribop_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .head_o  (head),
    .count_o (count)
  );

  assign kind_o        = head.kind;
  assign mapper_id_o   = head.mapper_id;
  assign submapper_o   = head.submapper;
  assign is_nes20_o    = head.is_nes20;
  assign has_battery_o = head.has_battery;
  assign has_trainer_o = head.has_trainer;
  assign mirroring_o   = head.mirroring;
  assign region_o      = head.region;
  assign bank_index_o  = head.bank_index;
  assign occupied_o    = head.occupied;
  assign status_o      = head.status;
  assign end_of_run_o  = head.end_of_run;

  a_fire_to_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> s1_valid_q)
    else $error("accepted transaction did not reach the input register");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= FIFO_CW'(FIFO_DEPTH))
    else $error("result queue overflow");

  a_last_gives_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_last_q) |->
      ((push.num == 2'd1 && push.res[0].kind == KIND_FINAL) ||
       (push.num == 2'd2 && push.res[1].kind == KIND_FINAL)))
    else $error("last byte did not produce a final status");

  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |=> count == $past(count) + FIFO_CW'($past(push.num)) - FIFO_CW'($past(pop)))
    else $error("result queue count mismatch");

endmodule

`default_nettype wire

// File: sim/rom_parse_checker.sv
// ----------------------------------------------------------------------------
// ROM image parse checker
// Watches the configuration, byte and result channels of the ROM image bank
// occupancy parser. It predicts the header, bank and final status reports of
// each accepted byte and compares every accepted report field by field.
// ----------------------------------------------------------------------------
module rom_parse_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [7:0]  cfg_empty_value_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  file_byte_i,
  input  logic        last_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [1:0]  kind_i,
  input  logic [11:0] mapper_id_i,
  input  logic [3:0]  submapper_i,
  input  logic        is_nes20_i,
  input  logic        has_battery_i,
  input  logic        has_trainer_i,
  input  logic [1:0]  mirroring_i,
  input  logic        region_i,
  input  logic [11:0] bank_index_i,
  input  logic [14:0] occupied_i,
  input  logic [2:0]  status_i,
  input  logic        end_of_run_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import ribop_pkg::*;

  phase_e      scan_phase;
  logic [7:0]  hdr_bytes [HEADER_BYTES];
  logic [9:0]  hdr_pos;
  logic [15:0] bank_fill;
  logic [14:0] occ_count;
  logic [11:0] bank_no;
  logic [11:0] prg_banks;
  logic [11:0] chr_banks;
  status_e     fault;
  logic        tail_seen;
  logic [7:0]  empty_val;

  result_t expected_reports [$];
  result_t step_reports [$];
  int      fail_count = 0;
  int      report_no = 0;

  assign fail_count_o = fail_count;

  task automatic report_mismatch(input string msg);
    $display("[%0t] result %0d: %s", $time, report_no, msg);
    fail_count++;
  endtask

  task automatic check_field(input string fname, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s is %0h, expected %0h", fname, got, want));
  endtask

  task automatic add_step_report(input result_t r);
    step_reports = {step_reports, r};
  endtask

  task automatic clear_image();
    scan_phase = PH_HEADER;
    foreach (hdr_bytes[i]) hdr_bytes[i] = '0;
    hdr_pos    = '0;
    bank_fill  = '0;
    occ_count  = '0;
    bank_no    = '0;
    prg_banks  = '0;
    chr_banks  = '0;
    fault      = ST_OK;
    tail_seen  = 1'b0;
  endtask

  task automatic enter_first_region();
    bank_no   = '0;
    bank_fill = '0;
    occ_count = '0;
    if (prg_banks != 0) scan_phase = PH_PRG;
    else if (chr_banks != 0) scan_phase = PH_CHR;
    else scan_phase = PH_END;
  endtask

  task automatic decode_header();
    logic        v2_form;
    logic [11:0] mapper;
    logic [3:0]  sub;
    logic [3:0]  prg_exp;
    logic [3:0]  chr_exp;
    result_t     r;
    if (hdr_bytes[0] != SIG_BYTE0 || hdr_bytes[1] != SIG_BYTE1 ||
        hdr_bytes[2] != SIG_BYTE2 || hdr_bytes[3] != SIG_BYTE3) begin
      fault      = ST_BAD_SIG;
      scan_phase = PH_ERROR;
      return;
    end
    v2_form   = (hdr_bytes[7] & FMT_MASK) == FMT_V2;
    mapper    = {4'h0, hdr_bytes[7][7:4], hdr_bytes[6][7:4]};
    sub       = '0;
    prg_banks = {4'h0, hdr_bytes[4]};
    chr_banks = {4'h0, hdr_bytes[5]};
    if (v2_form) begin
      prg_exp        = hdr_bytes[9][3:0];
      chr_exp        = hdr_bytes[9][7:4];
      mapper[11:8]   = hdr_bytes[8][3:0];
      sub            = hdr_bytes[8][7:4];
      if (prg_exp == EXP_SIZE || chr_exp == EXP_SIZE) begin
        fault      = ST_UNSUP;
        scan_phase = PH_ERROR;
        return;
      end
      prg_banks[11:8] = prg_exp;
      chr_banks[11:8] = chr_exp;
    end
    r             = '0;
    r.kind        = KIND_HEADER;
    r.mapper_id   = mapper;
    r.submapper   = sub;
    r.is_nes20    = v2_form;
    r.has_battery = |(hdr_bytes[6] & FLAG_BATT);
    r.has_trainer = |(hdr_bytes[6] & FLAG_TRAIN);
    if (|(hdr_bytes[6] & FLAG_FOUR)) r.mirroring = MIR_FOUR;
    else if (|(hdr_bytes[6] & FLAG_VERT)) r.mirroring = MIR_VERT;
    else r.mirroring = MIR_HORIZ;
    add_step_report(r);
    hdr_pos = '0;
    if (r.has_trainer) scan_phase = PH_TRAINER;
    else enter_first_region();
  endtask

  task automatic count_bank_byte(input logic [7:0] b);
    logic    in_chr;
    int      bank_len;
    result_t r;
    in_chr   = scan_phase == PH_CHR;
    bank_len = in_chr ? CHR_BANK_BYTES : PRG_BANK_BYTES;
    if (b != empty_val) occ_count++;
    bank_fill++;
    if (bank_fill < bank_len) return;
    r            = '0;
    r.kind       = KIND_BANK;
    r.region     = in_chr ? REG_CHR : REG_PRG;
    r.bank_index = bank_no;
    r.occupied   = occ_count;
    add_step_report(r);
    bank_fill = '0;
    occ_count = '0;
    bank_no++;
    if (!in_chr && bank_no >= prg_banks) begin
      bank_no    = '0;
      scan_phase = (chr_banks != 0) ? PH_CHR : PH_END;
    end else if (in_chr && bank_no >= chr_banks) begin
      bank_no    = '0;
      scan_phase = PH_END;
    end
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic lst);
    result_t r;
    step_reports.delete();
    case (scan_phase)
      PH_HEADER: begin
        hdr_bytes[hdr_pos[3:0]] = b;
        hdr_pos++;
        if (hdr_pos >= HEADER_BYTES) decode_header();
      end
      PH_TRAINER: begin
        hdr_pos++;
        if (hdr_pos >= TRAINER_BYTES) begin
          hdr_pos = '0;
          enter_first_region();
        end
      end
      PH_PRG, PH_CHR: count_bank_byte(b);
      PH_END: tail_seen = 1'b1;
      default: ;
    endcase
    if (lst) begin
      r      = '0;
      r.kind = KIND_FINAL;
      if (scan_phase == PH_HEADER) r.status = ST_SHORT;
      else if (fault != ST_OK) r.status = fault;
      else if (scan_phase == PH_END) r.status = tail_seen ? ST_TRAILING : ST_OK;
      else r.status = ST_TRUNCATED;
      add_step_report(r);
      clear_image();
    end
    if (step_reports.size() > 0) step_reports[step_reports.size() - 1].end_of_run = 1'b1;
    expected_reports = {expected_reports, step_reports};
  endtask

  task automatic compare_report();
    result_t want;
    report_no++;
    if (expected_reports.size() == 0) begin
      report_mismatch("result with no expectation waiting");
      return;
    end
    want = expected_reports.pop_front();
    check_field("kind", kind_i, want.kind);
    check_field("mapper_id", mapper_id_i, want.mapper_id);
    check_field("submapper", submapper_i, want.submapper);
    check_field("is_nes20", is_nes20_i, want.is_nes20);
    check_field("has_battery", has_battery_i, want.has_battery);
    check_field("has_trainer", has_trainer_i, want.has_trainer);
    check_field("mirroring", mirroring_i, want.mirroring);
    check_field("region", region_i, want.region);
    check_field("bank_index", bank_index_i, want.bank_index);
    check_field("occupied", occupied_i, want.occupied);
    check_field("status", status_i, want.status);
    check_field("end_of_run", end_of_run_i, want.end_of_run);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      empty_val = '0;
      clear_image();
      expected_reports.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) compare_report();
      if (cfg_valid_i && cfg_ready_i) empty_val = cfg_empty_value_i;
      if (in_valid_i && in_ready_i) parse_byte(file_byte_i, last_i);
      pending_o <= expected_reports.size();
    end
  end

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// ROM image bank occupancy parser testbench
// Streams directed cartridge images, then random ones under several sender
// and receiver stall patterns and empty values, and leaves the prediction and
// comparison of all reports to the checker.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ribop_pkg::*;

  logic        clk_i             = 1'b0;
  logic        rst_ni            = 1'b0;
  logic        cfg_valid_i       = 1'b0;
  logic [7:0]  cfg_empty_value_i = '0;
  logic        in_valid_i        = 1'b0;
  logic [7:0]  file_byte_i       = '0;
  logic        last_i            = 1'b0;
  logic        out_ready_i       = 1'b0;
  logic        cfg_ready_o;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [1:0]  kind_o;
  logic [11:0] mapper_id_o;
  logic [3:0]  submapper_o;
  logic        is_nes20_o;
  logic        has_battery_o;
  logic        has_trainer_o;
  logic [1:0]  mirroring_o;
  logic        region_o;
  logic [11:0] bank_index_o;
  logic [14:0] occupied_o;
  logic [2:0]  status_o;
  logic        end_of_run_o;

  int         fail_count;
  int         pending;
  int         send_idle_pct  = 0;
  int         recv_stall_pct = 0;
  int         fill_pct       = 50;
  int         budget;
  logic [7:0] empty_now      = '0;
  logic [7:0] hdr [HEADER_BYTES];

  rom_image_bank_occupancy_parser uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_empty_value_i (cfg_empty_value_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .file_byte_i       (file_byte_i),
    .last_i            (last_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .kind_o            (kind_o),
    .mapper_id_o       (mapper_id_o),
    .submapper_o       (submapper_o),
    .is_nes20_o        (is_nes20_o),
    .has_battery_o     (has_battery_o),
    .has_trainer_o     (has_trainer_o),
    .mirroring_o       (mirroring_o),
    .region_o          (region_o),
    .bank_index_o      (bank_index_o),
    .occupied_o        (occupied_o),
    .status_o          (status_o),
    .end_of_run_o      (end_of_run_o)
  );

  rom_parse_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_i       (cfg_ready_o),
    .cfg_empty_value_i (cfg_empty_value_i),
    .in_valid_i        (in_valid_i),
    .in_ready_i        (in_ready_o),
    .file_byte_i       (file_byte_i),
    .last_i            (last_i),
    .out_valid_i       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .kind_i            (kind_o),
    .mapper_id_i       (mapper_id_o),
    .submapper_i       (submapper_o),
    .is_nes20_i        (is_nes20_o),
    .has_battery_i     (has_battery_o),
    .has_trainer_i     (has_trainer_o),
    .mirroring_i       (mirroring_o),
    .region_i          (region_o),
    .bank_index_i      (bank_index_o),
    .occupied_i        (occupied_o),
    .status_i          (status_o),
    .end_of_run_i      (end_of_run_o),
    .fail_count_o      (fail_count),
    .pending_o         (pending)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_byte(input logic [7:0] b, input logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    file_byte_i <= b;
    last_i      <= lst;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic write_empty(input logic [7:0] v);
    cfg_valid_i       <= 1'b1;
    cfg_empty_value_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    empty_now = v;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic int image_len(input int prg, input int chr, input logic trn);
    return HEADER_BYTES + (trn ? TRAINER_BYTES : 0) + prg * PRG_BANK_BYTES +
           chr * CHR_BANK_BYTES;
  endfunction

  function automatic int pick_fill();
    int r;
    r = $urandom_range(2);
    if (r == 0) return 0;
    if (r == 1) return 100;
    return $urandom_range(99, 1);
  endfunction

  function automatic logic [7:0] body_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    if (fill_pct == 0) begin
      if (b == empty_now) b = ~b;
    end else if ($urandom_range(99) < fill_pct) begin
      b = empty_now;
    end
    return b;
  endfunction

  task automatic make_header(input logic v2, input int prg, input int chr, input logic trn);
    hdr[0] = SIG_BYTE0;
    hdr[1] = SIG_BYTE1;
    hdr[2] = SIG_BYTE2;
    hdr[3] = SIG_BYTE3;
    hdr[4] = 8'(prg);
    hdr[5] = 8'(chr);
    hdr[6] = 8'($urandom_range(255));
    if (trn) hdr[6] |= FLAG_TRAIN;
    else hdr[6] &= ~FLAG_TRAIN;
    hdr[7] = 8'($urandom_range(255));
    if (v2) hdr[7] = (hdr[7] & ~FMT_MASK) | FMT_V2;
    else if ((hdr[7] & FMT_MASK) == FMT_V2) hdr[7] ^= 8'h04;
    hdr[8] = 8'($urandom_range(255));
    if (v2) hdr[9] = {4'(chr >> 8), 4'(prg >> 8)};
    else hdr[9] = 8'($urandom_range(255));
    for (int i = 10; i < HEADER_BYTES; i++) hdr[i] = 8'($urandom_range(255));
  endtask

  task automatic send_image(input int total);
    for (int i = 0; i < total; i++) begin
      send_byte((i < HEADER_BYTES) ? hdr[i] : body_byte(), i == total - 1);
    end
  endtask

  task automatic directed_images();
    fill_pct = 50;
    make_header(1'b0, 0, 0, 1'b0);
    hdr[0] = 8'hFF;
    send_image(1);
    make_header(1'b1, 0, 0, 1'b0);
    send_image(15);
    make_header(1'b0, 0, 0, 1'b0);
    hdr[6] = 8'hFB;
    hdr[7] = 8'hF0;
    send_image(16);
    hdr[6] = 8'h01;
    hdr[7] = 8'h00;
    send_image(19);
    make_header(1'b1, 0, 0, 1'b0);
    hdr[6] = 8'hF2;
    hdr[7] = 8'hF8;
    hdr[8] = 8'hFF;
    send_image(16);
    for (int k = 0; k < 4; k++) begin
      make_header(1'b0, 0, 0, 1'b0);
      hdr[k] ^= 8'h20;
      send_image(16 + 3 * k);
    end
    make_header(1'b1, 0, 0, 1'b0);
    hdr[9] = 8'h0F;
    send_image(20);
    hdr[9] = 8'hF0;
    send_image(16);
    make_header(1'b0, 0, 0, 1'b1);
    send_image(image_len(0, 0, 1'b1));
    make_header(1'b0, 1, 0, 1'b0);
    send_image(16);
  endtask

  task automatic random_image();
    int   pick;
    int   len;
    int   prg;
    int   chr;
    int   bank_max;
    logic v2;
    logic trn;
    pick     = $urandom_range(99);
    v2       = 1'($urandom_range(1));
    trn      = ($urandom_range(99) < 20);
    fill_pct = pick_fill();
    bank_max = v2 ? 'hEFF : 255;
    if (pick < 15) begin
      make_header(v2, 0, 0, trn);
      len = $urandom_range(15, 1);
    end else if (pick < 35) begin
      make_header(v2, 0, 0, trn);
      hdr[$urandom_range(3)] ^= 8'(1 << $urandom_range(7));
      len = $urandom_range(24, 16);
    end else if (pick < 50) begin
      make_header(1'b1, 0, 0, trn);
      hdr[9] = 8'($urandom_range(255));
      if ($urandom_range(1)) hdr[9][3:0] = EXP_SIZE;
      else hdr[9][7:4] = EXP_SIZE;
      len = $urandom_range(24, 16);
    end else if (pick < 75) begin
      if ($urandom_range(1)) begin
        prg = $urandom_range(bank_max, 1);
        chr = $urandom_range(bank_max);
      end else begin
        prg = 0;
        chr = $urandom_range(bank_max, 1);
      end
      make_header(v2, prg, chr, trn);
      len = $urandom_range(24, 16);
    end else begin
      make_header(v2, 0, 0, 1'b0);
      len = HEADER_BYTES + ($urandom_range(1) ? 0 : $urandom_range(6, 1));
    end
    send_image(len);
    budget -= len;
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      settle();
      if (ph == 0) write_empty(8'h00);
      else if (ph == 1) write_empty(8'hFF);
      else write_empty(8'($urandom_range(255)));
      if (ph == 0) directed_images();
      budget = 80;
      while (budget > 0) random_image();
    end
    settle();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #200_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// File: rom_image_bank_occupancy_parser.f
rtl/ribop_pkg.sv
rtl/ribop_fifo.sv
rtl/ribop_core.sv
rtl/rom_image_bank_occupancy_parser.sv
sim/rom_parse_checker.sv
sim/tb_top.sv
